// File: rtl/rmwl_pkg.sv
// ============================================================================
// rmwl_pkg
// Shared types, codes and the conflict test for the reader/may-write/writer
// lock arbiter.
// ============================================================================
package rmwl_pkg;

    // Field widths fixed by the transaction format
    localparam int unsigned C_FUNC_W  = 3;
    localparam int unsigned C_ID_W    = 6;
    localparam int unsigned C_KIND_W  = 3;
    localparam int unsigned C_MODE_W  = 2;
    localparam int unsigned C_RC_W    = 7;

    // Number of known requesters; ids at or above this are rejected
    localparam logic [C_ID_W:0] C_REQUESTERS = 7'd64;

    // Reader count saturation point
    localparam logic [C_RC_W-1:0] C_READER_MAX = 7'd127;

    // Request functions
    localparam logic [C_FUNC_W-1:0] FUNC_READ     = 3'd0;
    localparam logic [C_FUNC_W-1:0] FUNC_MAYWRITE = 3'd1;
    localparam logic [C_FUNC_W-1:0] FUNC_WRITE    = 3'd2;
    localparam logic [C_FUNC_W-1:0] FUNC_UPGRADE  = 3'd3;
    localparam logic [C_FUNC_W-1:0] FUNC_REL_SH   = 3'd4;
    localparam logic [C_FUNC_W-1:0] FUNC_REL_EX   = 3'd5;

    // Result kinds
    localparam logic [C_KIND_W-1:0] KIND_GRANTED = 3'd0;
    localparam logic [C_KIND_W-1:0] KIND_QUEUED  = 3'd1;
    localparam logic [C_KIND_W-1:0] KIND_ERROR   = 3'd2;
    localparam logic [C_KIND_W-1:0] KIND_WAITER  = 3'd3;
    localparam logic [C_KIND_W-1:0] KIND_DONE    = 3'd4;

    // Lock modes
    localparam logic [C_MODE_W-1:0] MODE_READ     = 2'd0;
    localparam logic [C_MODE_W-1:0] MODE_MAYWRITE = 2'd1;
    localparam logic [C_MODE_W-1:0] MODE_WRITE    = 2'd2;
    localparam logic [C_MODE_W-1:0] MODE_UPGRADED = 2'd3;

    // One wait queue entry
    typedef struct packed {
        logic [C_MODE_W-1:0] mode;
        logic [C_ID_W-1:0]   id;
    } t_entry;

    // Conflict test of a requested mode against the current holders
    function automatic logic f_conflict(
        input logic [C_MODE_W-1:0] mode,
        input logic                writer,
        input logic                maywriter,
        input logic                upgrade,
        input logic [C_RC_W-1:0]   readers
    );
        logic res;
        priority if (mode == MODE_READ) begin
            res = writer | upgrade | (readers == C_READER_MAX);
        end else if (mode == MODE_MAYWRITE) begin
            res = writer | maywriter | upgrade;
        end else begin
            res = writer | (readers != '0) | maywriter | upgrade;
        end
        return res;
    endfunction

endpackage

// File: rtl/read_maywrite_write_lock_arbiter_unit.sv
// ============================================================================
// read_maywrite_write_lock_arbiter_unit
// Lock arbiter for one shared resource: read, may-write and write modes with
// upgrade, and a FIFO wait queue held in a RAM.
// ============================================================================
// Usage:
//   Requests arrive on the input channel (i_in_valid / o_in_ready) as a
//   function code and a requester id. Results leave on the output channel
//   (o_out_valid / i_out_ready), one transaction per result; o_last marks the
//   final result belonging to a request.
//   A lock request's result is loaded into the output register at the edge
//   that takes it, as is the single result of an upgrade or a rejected
//   request. An accepted release moves on to the sequencer instead: a
//   shared release that leaves readers behind goes straight to its done
//   result, one that grants a pending upgrade issues that grant first. Any
//   other release walks the queue: it reads the queue RAM at the head and
//   issues one grant per cycle while the receiver is ready, until it finds
//   the stopping entry or the empty queue; the done result comes last.
//   A new request can be taken at the edge at which the previous result
//   leaves the output register.
//   Reset (synchronous, active low) clears all holder state and empties the
//   queue; queue RAM contents are left as they are.
//   A stalled receiver holds the current result and pauses the walk.
// ============================================================================
module read_maywrite_write_lock_arbiter_unit #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Request channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [rmwl_pkg::C_FUNC_W-1:0]  i_func,
    input  logic [rmwl_pkg::C_ID_W-1:0]    i_requester_id,
    // Result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [rmwl_pkg::C_KIND_W-1:0]  o_result_kind,
    output logic [rmwl_pkg::C_ID_W-1:0]    o_grant_id,
    output logic [rmwl_pkg::C_MODE_W-1:0]  o_grant_mode,
    output logic                           o_last
);

    import rmwl_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    // Sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_UPG   = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    // Control state
    logic [1:0]        r_state, n_state;
    logic [C_RC_W-1:0] r_readers, n_readers;
    logic              r_writer, n_writer;
    logic              r_maywriter, n_maywriter;
    logic [C_ID_W-1:0] r_mw_owner, n_mw_owner;
    logic              r_upgrade, n_upgrade;
    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_out_valid, n_out_valid;

    // Payload
    logic [C_ID_W-1:0]   r_caller, n_caller;
    logic [C_KIND_W-1:0] r_kind, n_kind;
    logic [C_ID_W-1:0]   r_id, n_id;
    logic [C_MODE_W-1:0] r_mode, n_mode;
    logic                r_last, n_last;

    // Queue RAM access
    logic   w_we;
    t_entry w_wentry;
    t_entry w_rentry;
    logic [$bits(t_entry)-1:0] w_rdata;

    // Helpers
    logic                w_slot;
    logic                w_accept;
    logic                w_grant;
    logic                w_load;
    logic [C_KIND_W-1:0] w_ld_kind;
    logic [C_ID_W-1:0]   w_ld_id;
    logic [C_MODE_W-1:0] w_ld_mode;
    logic                w_ld_last;
    logic [C_RC_W-1:0]   w_readers_dec;
    logic                w_owner;

    assign w_slot     = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_slot;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_rentry   = t_entry'(w_rdata);
    assign w_readers_dec = r_readers - 1'b1;
    assign w_owner    = r_maywriter && !r_upgrade && (r_mw_owner == i_requester_id);

    // Wait queue storage
    rmwl_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_tail),
        .i_wdata (w_wentry),
        .i_raddr (n_head),
        .o_rdata (w_rdata)
    );

    // Sequencer and lock state update
    always_comb begin
        n_state     = r_state;
        n_readers   = r_readers;
        n_writer    = r_writer;
        n_maywriter = r_maywriter;
        n_mw_owner  = r_mw_owner;
        n_upgrade   = r_upgrade;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_caller    = r_caller;
        w_we        = 1'b0;
        w_wentry    = '{mode: i_func[C_MODE_W-1:0], id: i_requester_id};
        w_grant     = 1'b0;
        w_load      = 1'b0;
        w_ld_kind   = KIND_ERROR;
        w_ld_id     = i_requester_id;
        w_ld_mode   = MODE_READ;
        w_ld_last   = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_load   = 1'b1;
                    n_caller = i_requester_id;
                    priority if ({1'b0, i_requester_id} >= C_REQUESTERS) begin
                        w_ld_kind = KIND_ERROR;
                        w_ld_mode = (i_func <= FUNC_UPGRADE) ? i_func[C_MODE_W-1:0]
                                                             : MODE_READ;
                    end else if (i_func <= FUNC_WRITE) begin
                        w_ld_mode = i_func[C_MODE_W-1:0];
                        priority if (!f_conflict(i_func[C_MODE_W-1:0], r_writer,
                                                 r_maywriter, r_upgrade, r_readers)
                                     && (r_count == '0)) begin
                            w_ld_kind = KIND_GRANTED;
                            priority if (i_func == FUNC_READ) begin
                                n_readers = r_readers + 1'b1;
                            end else if (i_func == FUNC_MAYWRITE) begin
                                n_maywriter = 1'b1;
                                n_mw_owner  = i_requester_id;
                            end else begin
                                n_writer = 1'b1;
                            end
                        end else if (r_count == CNT_FULL) begin
                            w_ld_kind = KIND_ERROR;
                        end else begin
                            w_ld_kind = KIND_QUEUED;
                            w_we      = 1'b1;
                            n_tail    = (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;
                            n_count   = r_count + 1'b1;
                        end
                    end else if (i_func == FUNC_UPGRADE) begin
                        w_ld_mode = MODE_UPGRADED;
                        priority if (!r_maywriter || (r_mw_owner != i_requester_id)
                                     || r_upgrade) begin
                            w_ld_kind = KIND_ERROR;
                        end else if (r_readers != '0) begin
                            w_ld_kind = KIND_QUEUED;
                            n_upgrade = 1'b1;
                        end else begin
                            w_ld_kind   = KIND_GRANTED;
                            n_maywriter = 1'b0;
                            n_writer    = 1'b1;
                        end
                    end else if (i_func == FUNC_REL_SH) begin
                        priority if (!w_owner && (r_readers == '0)) begin
                            w_ld_kind = KIND_ERROR;
                        end else if (w_owner) begin
                            // may-writer gives up; walk the queue
                            w_load      = 1'b0;
                            n_maywriter = 1'b0;
                            n_state     = S_CHECK;
                        end else begin
                            w_load    = 1'b0;
                            n_readers = w_readers_dec;
                            priority if (w_readers_dec != '0) begin
                                n_state = S_DONE;
                            end else if (r_upgrade) begin
                                n_state = S_UPG;
                            end else begin
                                n_state = S_CHECK;
                            end
                        end
                    end else if (i_func == FUNC_REL_EX) begin
                        if (r_writer) begin
                            w_load   = 1'b0;
                            n_writer = 1'b0;
                            n_state  = S_CHECK;
                        end else begin
                            w_ld_kind = KIND_ERROR;
                        end
                    end else begin
                        w_ld_kind = KIND_ERROR;
                    end
                end
            end
            S_CHECK: begin
                // head entry read last cycle is on w_rentry
                if ((r_count == '0) || f_conflict(w_rentry.mode, r_writer, r_maywriter,
                                                  r_upgrade, r_readers)) begin
                    n_state = S_DONE;
                end else if (w_slot) begin
                    w_grant   = 1'b1;
                    w_load    = 1'b1;
                    w_ld_kind = KIND_WAITER;
                    w_ld_id   = w_rentry.id;
                    w_ld_mode = w_rentry.mode;
                    w_ld_last = 1'b0;
                    priority if (w_rentry.mode == MODE_READ) begin
                        n_readers = r_readers + 1'b1;
                    end else if (w_rentry.mode == MODE_MAYWRITE) begin
                        n_maywriter = 1'b1;
                        n_mw_owner  = w_rentry.id;
                    end else begin
                        n_writer = 1'b1;
                    end
                    n_head  = (r_head == PTR_LAST) ? '0 : r_head + 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            S_UPG: begin
                if (w_slot) begin
                    w_load      = 1'b1;
                    w_ld_kind   = KIND_WAITER;
                    w_ld_id     = r_mw_owner;
                    w_ld_mode   = MODE_UPGRADED;
                    w_ld_last   = 1'b0;
                    n_upgrade   = 1'b0;
                    n_maywriter = 1'b0;
                    n_writer    = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                if (w_slot) begin
                    w_load    = 1'b1;
                    w_ld_kind = KIND_DONE;
                    w_ld_id   = r_caller;
                    w_ld_mode = MODE_READ;
                    w_ld_last = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_kind      = r_kind;
        n_id        = r_id;
        n_mode      = r_mode;
        n_last      = r_last;
        if (w_load) begin
            n_out_valid = 1'b1;
            n_kind      = w_ld_kind;
            n_id        = w_ld_id;
            n_mode      = w_ld_mode;
            n_last      = w_ld_last;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_readers   <= '0;
            r_writer    <= 1'b0;
            r_maywriter <= 1'b0;
            r_mw_owner  <= '0;
            r_upgrade   <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_readers   <= n_readers;
            r_writer    <= n_writer;
            r_maywriter <= n_maywriter;
            r_mw_owner  <= n_mw_owner;
            r_upgrade   <= n_upgrade;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_caller <= n_caller;
        r_kind   <= n_kind;
        r_id     <= n_id;
        r_mode   <= n_mode;
        r_last   <= n_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_kind;
    assign o_grant_id    = r_id;
    assign o_grant_mode  = r_mode;
    assign o_last        = r_last;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("wait queue count beyond depth");

    a_writer_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_writer |-> ((r_readers == '0) && !r_maywriter))
        else $error("writer held together with readers or may-writer");

    a_upgrade_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_upgrade |-> r_maywriter)
        else $error("pending upgrade without a may-writer");

    a_walk_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_grant |=> (o_out_valid && (o_result_kind == KIND_WAITER) && !o_last))
        else $error("queue grant not presented on the output");

endmodule

// File: rtl/rmwl_ram.sv
// ============================================================================
// rmwl_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ============================================================================
module rmwl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: test/read_maywrite_write_lock_arbiter_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// read_maywrite_write_lock_arbiter_unit_checker
// Watches both channels of the lock arbiter and keeps its own model of the
// holders and the FIFO wait queue. Every request transaction predicts its run
// of results. Each result transaction is compared field by field with the
// oldest prediction, and failures are counted for the testbench top.
// ----------------------------------------------------------------------------
module read_maywrite_write_lock_arbiter_unit_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Request channel
    input  logic                          i_req_valid,
    input  logic                          i_req_ready,
    input  logic [rmwl_pkg::C_FUNC_W-1:0] i_req_func,
    input  logic [rmwl_pkg::C_ID_W-1:0]   i_req_id,
    // Result channel
    input  logic                          i_res_valid,
    input  logic                          i_res_ready,
    input  logic [rmwl_pkg::C_KIND_W-1:0] i_res_kind,
    input  logic [rmwl_pkg::C_ID_W-1:0]   i_res_id,
    input  logic [rmwl_pkg::C_MODE_W-1:0] i_res_mode,
    input  logic                          i_res_last,
    // Status for the top
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_checked
);
    import rmwl_pkg::*;

    localparam int unsigned WAIT_SLOTS = 16;

    typedef struct packed {
        logic [C_KIND_W-1:0] kind;
        logic [C_ID_W-1:0]   id;
        logic [C_MODE_W-1:0] mode;
        logic                last;
    } t_lock_result;

    // Holder state
    logic [C_RC_W-1:0]   readers;
    logic                writer_held;
    logic                maywriter_held;
    logic [C_ID_W-1:0]   maywriter_id;
    logic                upgrade_waiting;

    // Wait queue
    logic [C_MODE_W-1:0] slot_mode [WAIT_SLOTS];
    logic [C_ID_W-1:0]   slot_id   [WAIT_SLOTS];
    logic [3:0]          head_ptr;
    logic [3:0]          tail_ptr;
    int unsigned         waiting;

    t_lock_result        step_results [$];
    t_lock_result        expected_q   [$];

    // Would a grant in this mode clash with the current holders?
    function automatic logic mode_blocked(input logic [C_MODE_W-1:0] m);
        if (m == MODE_READ)
            return writer_held | upgrade_waiting | (readers == C_READER_MAX);
        if (m == MODE_MAYWRITE)
            return writer_held | maywriter_held | upgrade_waiting;
        return writer_held | (readers != '0) | maywriter_held | upgrade_waiting;
    endfunction

    task automatic note(input logic [C_KIND_W-1:0] k, input logic [C_ID_W-1:0] rid,
                        input logic [C_MODE_W-1:0] m);
        step_results.push_back('{kind: k, id: rid, mode: m, last: 1'b0});
    endtask

    // Counters move at grant time
    task automatic hand_over(input logic [C_MODE_W-1:0] m, input logic [C_ID_W-1:0] rid);
        if (m == MODE_READ) begin
            readers = readers + 1'b1;
        end else if (m == MODE_MAYWRITE) begin
            maywriter_held = 1'b1;
            maywriter_id   = rid;
        end else begin
            writer_held = 1'b1;
        end
    endtask

    // Grant waiters from the head until one clashes
    task automatic drain_waiters();
        logic [C_MODE_W-1:0] m;
        logic [C_ID_W-1:0]   rid;
        while (waiting != 0) begin
            m   = slot_mode[head_ptr];
            rid = slot_id[head_ptr];
            if (mode_blocked(m))
                break;
            hand_over(m, rid);
            head_ptr = head_ptr + 1'b1;
            waiting--;
            note(KIND_WAITER, rid, m);
        end
    endtask

    // Work out the run of results for one request transaction.
    // Mode 0 doubles as "no mode" on release and unknown-function results.
    task automatic predict_request(input logic [C_FUNC_W-1:0] f,
                                   input logic [C_ID_W-1:0] rid);
        logic owner;
        step_results.delete();
        if ({1'b0, rid} >= C_REQUESTERS) begin
            note(KIND_ERROR, rid, (f <= FUNC_UPGRADE) ? f[C_MODE_W-1:0] : MODE_READ);
        end else if (f <= FUNC_WRITE) begin
            if (!mode_blocked(f[C_MODE_W-1:0]) && waiting == 0) begin
                hand_over(f[C_MODE_W-1:0], rid);
                note(KIND_GRANTED, rid, f[C_MODE_W-1:0]);
            end else if (waiting >= WAIT_SLOTS) begin
                note(KIND_ERROR, rid, f[C_MODE_W-1:0]);
            end else begin
                slot_mode[tail_ptr] = f[C_MODE_W-1:0];
                slot_id[tail_ptr]   = rid;
                tail_ptr = tail_ptr + 1'b1;
                waiting++;
                note(KIND_QUEUED, rid, f[C_MODE_W-1:0]);
            end
        end else if (f == FUNC_UPGRADE) begin
            if (!maywriter_held || maywriter_id != rid || upgrade_waiting) begin
                note(KIND_ERROR, rid, MODE_UPGRADED);
            end else if (readers != '0) begin
                upgrade_waiting = 1'b1;
                note(KIND_QUEUED, rid, MODE_UPGRADED);
            end else begin
                maywriter_held = 1'b0;
                writer_held    = 1'b1;
                note(KIND_GRANTED, rid, MODE_UPGRADED);
            end
        end else if (f == FUNC_REL_SH) begin
            // may-writer gives up its lock, otherwise one reader leaves
            owner = maywriter_held && !upgrade_waiting && maywriter_id == rid;
            if (!owner && readers == '0) begin
                note(KIND_ERROR, rid, MODE_READ);
            end else begin
                if (owner) begin
                    maywriter_held = 1'b0;
                    drain_waiters();
                end else begin
                    readers = readers - 1'b1;
                end
                if (readers == '0) begin
                    if (upgrade_waiting) begin
                        upgrade_waiting = 1'b0;
                        maywriter_held  = 1'b0;
                        writer_held     = 1'b1;
                        note(KIND_WAITER, maywriter_id, MODE_UPGRADED);
                    end else begin
                        drain_waiters();
                    end
                end
                note(KIND_DONE, rid, MODE_READ);
            end
        end else if (f == FUNC_REL_EX) begin
            if (!writer_held) begin
                note(KIND_ERROR, rid, MODE_READ);
            end else begin
                writer_held = 1'b0;
                drain_waiters();
                note(KIND_DONE, rid, MODE_READ);
            end
        end else begin
            note(KIND_ERROR, rid, MODE_READ);
        end
        step_results[step_results.size()-1].last = 1'b1;
        foreach (step_results[k])
            expected_q.push_back(step_results[k]);
    endtask

    task automatic report_mismatch(input string what);
        o_fail_count++;
        if (o_fail_count <= 40)
            $display("[%0t] lock result mismatch: %s", $realtime, what);
    endtask

    // Both channels are sampled at the rising edge; results go first since a
    // result never belongs to a request taken at the same edge
    always @(posedge i_clk) begin
        t_lock_result want;
        if (!i_rst_n) begin
            readers         = '0;
            writer_held     = 1'b0;
            maywriter_held  = 1'b0;
            maywriter_id    = '0;
            upgrade_waiting = 1'b0;
            head_ptr        = '0;
            tail_ptr        = '0;
            waiting         = 0;
            expected_q.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0d id %0d mode %0d",
                                              i_res_kind, i_res_id, i_res_mode));
                end else begin
                    want = expected_q.pop_front();
                    o_checked++;
                    if (i_res_kind !== want.kind)
                        report_mismatch($sformatf("result_kind %0d, want %0d (id %0d)",
                                                  i_res_kind, want.kind, want.id));
                    if (i_res_id !== want.id)
                        report_mismatch($sformatf("grant_id %0d, want %0d",
                                                  i_res_id, want.id));
                    if (i_res_mode !== want.mode)
                        report_mismatch($sformatf("grant_mode %0d, want %0d (id %0d)",
                                                  i_res_mode, want.mode, want.id));
                    if (i_res_last !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b (id %0d)",
                                                  i_res_last, want.last, want.id));
                end
            end
            if (i_req_valid && i_req_ready)
                predict_request(i_req_func, i_req_id);
        end
        o_pending = expected_q.size();
    end

endmodule

// File: test/read_maywrite_write_lock_arbiter_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// read_maywrite_write_lock_arbiter_unit_test
// Drives lock requests into the arbiter: a directed pass over every function,
// error path, waiting upgrade and a full wait queue, then random traffic from
// a small set of requesters. Both sides idle in random bursts. The checker
// beside the block predicts and compares.
// ----------------------------------------------------------------------------
module read_maywrite_write_lock_arbiter_unit_test;
    import rmwl_pkg::*;

    localparam int RANDOM_ITEMS = 128;
    localparam int QUIET_ITEMS  = 32;
    localparam int DRAIN_CYCLES = 40;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    logic [C_FUNC_W-1:0] req_func  = '0;
    logic [C_ID_W-1:0]   req_id    = '0;
    logic                res_valid;
    logic                res_ready = 1'b0;
    logic [C_KIND_W-1:0] res_kind;
    logic [C_ID_W-1:0]   res_id;
    logic [C_MODE_W-1:0] res_mode;
    logic                res_last;

    int                  fail_count;
    int                  pending;
    int                  checked;
    int                  n_sent      = 0;
    bit                  gaps_on     = 1'b1;
    bit                  stall_on    = 1'b1;
    logic [C_ID_W-1:0]   last_mw_id  = '0;

    read_maywrite_write_lock_arbiter_unit u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (req_valid),
        .o_in_ready     (req_ready),
        .i_func         (req_func),
        .i_requester_id (req_id),
        .o_out_valid    (res_valid),
        .i_out_ready    (res_ready),
        .o_result_kind  (res_kind),
        .o_grant_id     (res_id),
        .o_grant_mode   (res_mode),
        .o_last         (res_last)
    );

    read_maywrite_write_lock_arbiter_unit_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_req_func   (req_func),
        .i_req_id     (req_id),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_res_kind   (res_kind),
        .i_res_id     (res_id),
        .i_res_mode   (res_mode),
        .i_res_last   (res_last),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // 12 ns clock
    initial begin
        forever #6 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #(10_000_000);
        $display("read_maywrite_write_lock_arbiter_unit_test NOT OK");
        $finish;
    end

    // Result-side back-pressure: random stall bursts between stretches of ready
    initial begin
        forever begin
            @(negedge clk);
            if (stall_on && $urandom_range(0, 5) == 0) begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            res_ready <= 1'b1;
            repeat ($urandom_range(0, 10)) @(negedge clk);
        end
    end

    // One request transaction, with an optional idle burst in front.
    // Valid stays high after acceptance unless the next call idles or the sender holds off.
    task automatic issue(input logic [C_FUNC_W-1:0] f, input logic [C_ID_W-1:0] rid);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_func  <= f;
        req_id    <= rid;
        do @(posedge clk); while (!req_ready);
        @(negedge clk);
        n_sent++;
        if (f == FUNC_MAYWRITE)
            last_mw_id = rid;
    endtask

    // Sender holds off until every predicted result has come out
    task automatic hold_until_drained();
        req_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    initial begin
        int                r;
        logic [C_FUNC_W-1:0] f;
        logic [C_ID_W-1:0] rid;
        logic [C_ID_W-1:0] id_pool [4];

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Upgrade with no readers is granted straight away
        issue(FUNC_MAYWRITE, 6'd7);
        issue(FUNC_UPGRADE, 6'd7);
        issue(FUNC_REL_EX, 6'd7);
        hold_until_drained();

        // Misuse from idle: releases with nothing held, bad upgrade, undefined codes
        issue(FUNC_REL_EX, 6'd0);
        issue(FUNC_REL_SH, 6'd63);
        issue(FUNC_UPGRADE, 6'd5);
        issue(FUNC_REL_EX + 3'd1, 6'd42);
        issue(FUNC_REL_EX + 3'd2, 6'd21);

        // Waiting upgrade, foreign and repeated upgrade, then grant on last reader out
        issue(FUNC_MAYWRITE, 6'd10);
        issue(FUNC_READ, 6'd63);
        issue(FUNC_UPGRADE, 6'd11);
        issue(FUNC_UPGRADE, 6'd10);
        issue(FUNC_UPGRADE, 6'd10);
        issue(FUNC_READ, 6'd1);
        issue(FUNC_REL_SH, 6'd20);

        // Writer held: fill the wait queue and overflow it
        issue(FUNC_READ, 6'd4);
        issue(FUNC_READ, 6'd5);
        issue(FUNC_MAYWRITE, 6'd3);
        issue(FUNC_READ, 6'd6);
        issue(FUNC_WRITE, 6'd2);
        repeat (10) issue(3'($urandom_range(FUNC_READ, FUNC_WRITE)), 6'($urandom));
        issue(FUNC_READ, 6'd63);

        // Multi-grant walk, then the may-writer drops its lock by shared release
        issue(FUNC_REL_EX, 6'd10);
        issue(FUNC_REL_SH, 6'd3);
        hold_until_drained();

        // Random traffic from a small rotating set of requesters
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2)
                hold_until_drained();
            if (n == RANDOM_ITEMS - QUIET_ITEMS) begin
                gaps_on  = 1'b0;
                stall_on = 1'b0;
            end
            if (n % 20 == 0) begin
                foreach (id_pool[k])
                    id_pool[k] = 6'($urandom);
            end
            rid = ($urandom_range(0, 9) == 0) ? 6'($urandom) : id_pool[$urandom_range(0, 3)];
            r = $urandom_range(0, 99);
            if (r < 22) begin
                f = FUNC_READ;
            end else if (r < 32) begin
                f = FUNC_MAYWRITE;
            end else if (r < 42) begin
                f = FUNC_WRITE;
            end else if (r < 52) begin
                f = FUNC_UPGRADE;
                if ($urandom_range(0, 3) != 0)
                    rid = last_mw_id;
            end else if (r < 80) begin
                f = FUNC_REL_SH;
                if ($urandom_range(0, 2) == 0)
                    rid = last_mw_id;
            end else if (r < 96) begin
                f = FUNC_REL_EX;
            end else begin
                // undefined codes above release exclusive
                f = FUNC_REL_EX + 3'($urandom_range(1, 2));
            end
            issue(f, rid);
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d requests: full wait queue, upgrade paths, queue walks,",
                 n_sent);
        $display("misuse errors and random traffic; %0d results compared.", checked);
        if (fail_count == 0) begin
            $display("read_maywrite_write_lock_arbiter_unit_test OK");
        end else begin
            $display("read_maywrite_write_lock_arbiter_unit_test NOT OK");
        end
        $finish;
    end

endmodule
